@@ design/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_SCALE  = 1'b0;  // word select of accel_full_scale

  localparam int unsigned SCALE_W     = 20;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd100000;

  // frame markers
  localparam logic [7:0]  HDR_FIRST   = 8'h03;
  localparam logic [7:0]  HDR_SECOND  = 8'hFC;
  localparam logic [7:0]  TRL_FIRST   = 8'hFC;
  localparam logic [7:0]  TRL_SECOND  = 8'h03;
  localparam logic [15:0] TYPE_MOTION = 16'h0003;
  localparam logic [15:0] TYPE_ENV    = 16'h0008;
  localparam logic [15:0] TYPE_EMPTY  = 16'hFC03;

  // payload store
  localparam int unsigned PAYLOAD_DEPTH = 20;
  localparam int unsigned IDX_W         = 5;
  localparam logic [IDX_W-1:0] MOTION_LAST = 5'd5;
  localparam logic [IDX_W-1:0] ENV_LAST    = 5'd19;

  // result field widths
  localparam int unsigned ACCEL_W = 21;
  localparam int unsigned SPEED_W = 31;
  localparam int unsigned TEMP_W  = 15;
  localparam int unsigned HUM_W   = 14;

  // fixed-point conversion constants
  localparam int unsigned ACCEL_SHIFT = 15;
  localparam logic [36:0] ACCEL_ROUND = 37'd32767;
  localparam logic [13:0] HUM_MUL     = 14'd10000;
  localparam logic [14:0] TIN_MUL     = 15'd20000;
  localparam logic [14:0] TOUT_MUL    = 15'd17500;
  localparam logic [15:0] TIN_OFS     = 16'd5000;
  localparam logic [15:0] TOUT_OFS    = 16'd4500;

  localparam logic FRAME_MOTION = 1'b0;
  localparam logic FRAME_ENV    = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_SKIP    = 4'b1000
  } sfd_phase_t;

  typedef enum logic [1:0] {
    KIND_MOTION  = 2'd0,
    KIND_ENV     = 2'd1,
    KIND_UNKNOWN = 2'd2
  } sfd_kind_t;

  // record request from the parser to the decoder
  typedef struct packed {
    logic fire;
    logic kind;
  } sfd_evt_t;

endpackage

@@ design/sfd_cfg.sv @@
// ----------------------------------------------------------------------------
// sfd_cfg
// APB-style register file holding the acceleration full-scale value.
// ----------------------------------------------------------------------------
module sfd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sfd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [sfd_pkg::SCALE_W-1:0]      scale
);

  logic [sfd_pkg::SCALE_W-1:0] scale_r;
  logic [sfd_pkg::SCALE_W-1:0] scale_nxt;
  logic                        hit;

  // byte lanes ignored, one word per register
  assign hit    = (paddr[sfd_pkg::CFG_ADDR_W-1] == sfd_pkg::REG_SCALE);
  assign pready = 1'b1;

  always_comb begin
    scale_nxt = scale_r;
    if (psel && penable && pwrite && hit) begin
      scale_nxt = pwdata[sfd_pkg::SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= sfd_pkg::SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  assign prdata = hit ? {{(sfd_pkg::CFG_DATA_W - sfd_pkg::SCALE_W){1'b0}}, scale_r}
                      : '0;
  assign scale  = scale_r;

endmodule

@@ design/sfd_parser.sv @@
// ----------------------------------------------------------------------------
// sfd_parser
// Byte-level frame parser: header hunt, type check, payload capture and
// trailer search. Raises a record request at an accepted trailer of a known type.
// ----------------------------------------------------------------------------
module sfd_parser (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [7:0]                                   in_rx_byte,
  input  logic                                         rec_free,
  output sfd_pkg::sfd_evt_t                            evt,
  output logic [sfd_pkg::PAYLOAD_DEPTH-1:0][7:0]       payload
);

  sfd_pkg::sfd_phase_t          phase_r, phase_nxt;
  sfd_pkg::sfd_kind_t           kind_r, kind_nxt;
  logic [7:0]                   prev_r, prev_nxt;
  logic [sfd_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [7:0]                   type_hi_r, type_hi_nxt;
  logic [7:0]                   store_r [sfd_pkg::PAYLOAD_DEPTH];
  logic                         accept;
  logic                         wr_en;
  logic                         fire;
  logic [15:0]                  type_word;
  logic [sfd_pkg::IDX_W-1:0]    last_idx;

  // only a byte that may close a frame needs room in the product stage
  assign in_ready  = rec_free ||
                     !(phase_r == sfd_pkg::PH_SKIP && prev_r == sfd_pkg::TRL_FIRST);
  assign accept    = in_valid && in_ready;
  assign type_word = {type_hi_r, in_rx_byte};
  assign last_idx  = (kind_r == sfd_pkg::KIND_ENV) ? sfd_pkg::ENV_LAST
                                                   : sfd_pkg::MOTION_LAST;

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    prev_nxt    = prev_r;
    idx_nxt     = idx_r;
    type_hi_nxt = type_hi_r;
    wr_en       = 1'b0;
    fire        = 1'b0;
    if (accept) begin
      case (phase_r)
        sfd_pkg::PH_HUNT: begin
          if (prev_r == sfd_pkg::HDR_FIRST && in_rx_byte == sfd_pkg::HDR_SECOND) begin
            phase_nxt = sfd_pkg::PH_TYPE;
            idx_nxt   = '0;
            prev_nxt  = '0;
          end else begin
            prev_nxt = in_rx_byte;
          end
        end
        sfd_pkg::PH_TYPE: begin
          prev_nxt = '0;
          if (idx_r == '0) begin
            type_hi_nxt = in_rx_byte;
            idx_nxt     = sfd_pkg::IDX_W'(1);
          end else begin
            idx_nxt = '0;
            case (type_word)
              sfd_pkg::TYPE_MOTION: begin
                kind_nxt  = sfd_pkg::KIND_MOTION;
                phase_nxt = sfd_pkg::PH_PAYLOAD;
              end
              sfd_pkg::TYPE_ENV: begin
                kind_nxt  = sfd_pkg::KIND_ENV;
                phase_nxt = sfd_pkg::PH_PAYLOAD;
              end
              // trailer right after the header: empty frame
              sfd_pkg::TYPE_EMPTY: begin
                phase_nxt = sfd_pkg::PH_HUNT;
              end
              default: begin
                kind_nxt  = sfd_pkg::KIND_UNKNOWN;
                phase_nxt = sfd_pkg::PH_SKIP;
              end
            endcase
          end
        end
        sfd_pkg::PH_PAYLOAD: begin
          wr_en    = 1'b1;
          prev_nxt = '0;
          idx_nxt  = idx_r + 1'b1;
          if (idx_r == last_idx) begin
            phase_nxt = sfd_pkg::PH_SKIP;
          end
        end
        sfd_pkg::PH_SKIP: begin
          if (prev_r == sfd_pkg::TRL_FIRST && in_rx_byte == sfd_pkg::TRL_SECOND) begin
            phase_nxt = sfd_pkg::PH_HUNT;
            prev_nxt  = '0;
            fire      = (kind_r != sfd_pkg::KIND_UNKNOWN);
          end else begin
            prev_nxt = in_rx_byte;
          end
        end
        default: begin
          phase_nxt = sfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sfd_pkg::PH_HUNT;
      kind_r    <= sfd_pkg::KIND_MOTION;
      prev_r    <= '0;
      idx_r     <= '0;
      type_hi_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      prev_r    <= prev_nxt;
      idx_r     <= idx_nxt;
      type_hi_r <= type_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[idx_r] <= in_rx_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < sfd_pkg::PAYLOAD_DEPTH; i++) begin
      payload[i] = store_r[i];
    end
  end

  assign evt.fire = fire;
  assign evt.kind = (kind_r == sfd_pkg::KIND_ENV) ? sfd_pkg::FRAME_ENV
                                                  : sfd_pkg::FRAME_MOTION;

  a_payload_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sfd_pkg::PH_PAYLOAD |-> kind_r != sfd_pkg::KIND_UNKNOWN)
    else $error("payload capture for an unknown frame type");

  a_motion_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sfd_pkg::PH_PAYLOAD && kind_r == sfd_pkg::KIND_MOTION)
      |-> idx_r <= sfd_pkg::MOTION_LAST)
    else $error("motion payload index past its end");

  a_fire_back_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (phase_r == sfd_pkg::PH_HUNT && prev_r == '0))
    else $error("record request did not return parser to header hunt");

endmodule

@@ design/sfd_decode.sv @@
// ----------------------------------------------------------------------------
// sfd_decode
// Record decoder: a product stage fed from the payload store, then a
// result register with the scaling, offsets and motion-frame zeroing.
// ----------------------------------------------------------------------------
module sfd_decode (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  sfd_pkg::sfd_evt_t                         evt,
  input  logic [sfd_pkg::PAYLOAD_DEPTH-1:0][7:0]    payload,
  input  logic [sfd_pkg::SCALE_W-1:0]               scale,
  output logic                                      rec_free,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      out_frame_kind,
  output logic signed [sfd_pkg::ACCEL_W-1:0]        out_accel_x,
  output logic signed [sfd_pkg::ACCEL_W-1:0]        out_accel_y,
  output logic signed [sfd_pkg::ACCEL_W-1:0]        out_accel_z,
  output logic [sfd_pkg::SPEED_W-1:0]               out_speed_value,
  output logic signed [sfd_pkg::TEMP_W-1:0]         out_inner_temp_centi,
  output logic [sfd_pkg::HUM_W-1:0]                 out_inner_humidity_centi,
  output logic signed [sfd_pkg::TEMP_W-1:0]         out_outer_temp_centi
);

  // product stage
  logic                         a_valid_r, a_valid_nxt;
  logic                         a_kind_r;
  logic signed [36:0]           ax_r, ay_r, az_r;
  logic [sfd_pkg::SPEED_W-1:0]  spd_r;
  logic [33:0]                  hum_r;
  logic [34:0]                  tin_r;
  logic [30:0]                  tout_r;

  // result register
  logic                         o_valid_r, o_valid_nxt;
  logic                         o_kind_r;
  logic signed [sfd_pkg::ACCEL_W-1:0] o_ax_r, o_ay_r, o_az_r;
  logic [sfd_pkg::SPEED_W-1:0]  o_spd_r;
  logic signed [sfd_pkg::TEMP_W-1:0]  o_tin_r, o_tout_r;
  logic [sfd_pkg::HUM_W-1:0]    o_hum_r;

  logic                         out_free;
  logic                         a_move;
  logic signed [20:0]           scale_s;
  logic [31:0]                  speed_word;
  logic [19:0]                  hum_raw, tin_raw;
  logic [15:0]                  tout_raw;
  logic signed [36:0]           ax_prod, ay_prod, az_prod;
  logic [31:0]                  tout_sum;
  logic [15:0]                  tout_quo;
  logic [15:0]                  tin_val, tout_val;

  assign out_free = !o_valid_r || out_ready;
  assign a_move   = a_valid_r && out_free;
  assign rec_free = !a_valid_r || out_free;

  assign scale_s    = $signed({1'b0, scale});
  assign speed_word = {payload[6], payload[7], payload[8], payload[9]};
  assign hum_raw    = {payload[11][3:0], payload[12], payload[13]};
  assign tin_raw    = {payload[15][3:0], payload[16], payload[17]};
  assign tout_raw   = {payload[18], payload[19]};

  assign ax_prod = $signed({payload[0], payload[1]}) * scale_s;
  assign ay_prod = $signed({payload[2], payload[3]}) * scale_s;
  assign az_prod = $signed({payload[4], payload[5]}) * scale_s;

  assign a_valid_nxt = evt.fire ? 1'b1 : (a_move ? 1'b0 : a_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.fire) begin
      a_kind_r <= evt.kind;
      ax_r     <= ax_prod;
      ay_r     <= ay_prod;
      az_r     <= az_prod;
      spd_r    <= speed_word[31] ? '0 : speed_word[sfd_pkg::SPEED_W-1:0];
      hum_r    <= 34'(hum_raw) * sfd_pkg::HUM_MUL;
      tin_r    <= 35'(tin_raw) * sfd_pkg::TIN_MUL;
      tout_r   <= 31'(tout_raw) * sfd_pkg::TOUT_MUL;
    end
  end

  // divide by 32768 truncating toward zero
  function automatic logic signed [sfd_pkg::ACCEL_W-1:0] accel_div(
    input logic signed [36:0] p
  );
    logic signed [36:0] biased;
    biased = p[36] ? (p + $signed(sfd_pkg::ACCEL_ROUND)) : p;
    return sfd_pkg::ACCEL_W'(biased >>> sfd_pkg::ACCEL_SHIFT);
  endfunction

  // floor(p / 65535) for p below 2^31
  assign tout_sum = {1'b0, tout_r} + {16'b0, 1'b0, tout_r[30:16]} + 32'd1;
  assign tout_quo = tout_sum[31:16];
  assign tin_val  = {1'b0, tin_r[34:20]} - sfd_pkg::TIN_OFS;
  assign tout_val = tout_quo - sfd_pkg::TOUT_OFS;

  assign o_valid_nxt = a_move ? 1'b1 : (out_ready ? 1'b0 : o_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      o_kind_r <= a_kind_r;
      o_ax_r   <= accel_div(ax_r);
      o_ay_r   <= accel_div(ay_r);
      o_az_r   <= accel_div(az_r);
      if (a_kind_r == sfd_pkg::FRAME_ENV) begin
        o_spd_r  <= spd_r;
        o_hum_r  <= hum_r[33:20];
        o_tin_r  <= $signed(tin_val[sfd_pkg::TEMP_W-1:0]);
        o_tout_r <= $signed(tout_val[sfd_pkg::TEMP_W-1:0]);
      end else begin
        o_spd_r  <= '0;
        o_hum_r  <= '0;
        o_tin_r  <= '0;
        o_tout_r <= '0;
      end
    end
  end

  assign out_valid                = o_valid_r;
  assign out_frame_kind           = o_kind_r;
  assign out_accel_x              = o_ax_r;
  assign out_accel_y              = o_ay_r;
  assign out_accel_z              = o_az_r;
  assign out_speed_value          = o_spd_r;
  assign out_inner_temp_centi     = o_tin_r;
  assign out_inner_humidity_centi = o_hum_r;
  assign out_outer_temp_centi     = o_tout_r;

  a_fire_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    evt.fire |-> rec_free)
    else $error("record request while product stage is blocked");

  a_held_record_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !out_free) |=> (a_valid_r && $stable(ax_r) && $stable(a_kind_r)))
    else $error("stalled record in product stage was lost or changed");

endmodule

@@ design/sensor_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_deframer_top
// Byte-stream sensor frame deframer with decoded record output.
// ----------------------------------------------------------------------------
// Takes one link byte per cycle while in_ready is high and turns each complete
// motion (type 0003) or environment (type 0008) frame between header 03 FC and
// trailer FC 03 into one decoded record; unknown and empty frames produce
// nothing. After its trailer byte is accepted, a record passes through the
// product stage (the three 16x21 acceleration multipliers and the humidity and
// temperature constant multipliers) and then the output register (scaling
// shifts, divide by 65535 and offsets). in_ready drops only when a possible
// trailer byte arrives while both the product stage and the result register
// hold records that the sink has not taken. The full-scale register is written
// through the APB port at word 0; the user must do so only while the stream is
// idle, which the block does not enforce. There is no start-up clearing pass.
module sensor_frame_deframer_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [sfd_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_frame_kind,
  output logic signed [sfd_pkg::ACCEL_W-1:0]    out_accel_x,
  output logic signed [sfd_pkg::ACCEL_W-1:0]    out_accel_y,
  output logic signed [sfd_pkg::ACCEL_W-1:0]    out_accel_z,
  output logic [sfd_pkg::SPEED_W-1:0]           out_speed_value,
  output logic signed [sfd_pkg::TEMP_W-1:0]     out_inner_temp_centi,
  output logic [sfd_pkg::HUM_W-1:0]             out_inner_humidity_centi,
  output logic signed [sfd_pkg::TEMP_W-1:0]     out_outer_temp_centi
);

  logic [sfd_pkg::SCALE_W-1:0]                scale;
  logic                                       rec_free;
  sfd_pkg::sfd_evt_t                          evt;
  logic [sfd_pkg::PAYLOAD_DEPTH-1:0][7:0]     payload;

  sfd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .scale   (scale)
  );

  sfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .rec_free   (rec_free),
    .evt        (evt),
    .payload    (payload)
  );

  sfd_decode u_decode (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .evt                      (evt),
    .payload                  (payload),
    .scale                    (scale),
    .rec_free                 (rec_free),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_frame_kind           (out_frame_kind),
    .out_accel_x              (out_accel_x),
    .out_accel_y              (out_accel_y),
    .out_accel_z              (out_accel_z),
    .out_speed_value          (out_speed_value),
    .out_inner_temp_centi     (out_inner_temp_centi),
    .out_inner_humidity_centi (out_inner_humidity_centi),
    .out_outer_temp_centi     (out_outer_temp_centi)
  );

endmodule
